// ===== rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none
package qrs_pkg;

  localparam int CoefW   = 16;                 // Q8.8 coefficient width
  localparam int OutW    = 32;                 // Q16.16 result width
  localparam int OutFrac = 16;
  localparam int DiscW   = 2 * CoefW + 2;      // b*b - 4*a*c, signed
  localparam int RadW    = DiscW + 2 * OutFrac; // |D| * 2^32
  localparam int SqSteps = RadW / 2;           // one root digit per stage
  localparam int RootW   = SqSteps;
  localparam int RemW    = RootW + 3;
  localparam int NbW     = CoefW + OutFrac + 1; // -b * 2^16, signed
  localparam int DenW    = CoefW + 2;          // 2*a, signed
  localparam int DmagW   = CoefW + 1;          // |2*a|
  localparam int NumW    = RootW + 2;          // |numerator| magnitude
  localparam int NumSW   = NumW + 1;           // signed numerator
  localparam int DvSteps = NumW;               // one quotient bit per stage

  typedef enum logic [1:0] {
    KIND_TWO_REAL = 2'd0,
    KIND_DOUBLE   = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_A_ZERO   = 2'd3
  } root_kind_t;

  typedef struct packed {
    root_kind_t              kind;
    logic signed [NbW-1:0]   nb;
    logic signed [DenW-1:0]  den;
  } qrs_meta_t;

endpackage
`default_nettype wire

// ===== rtl/qrs_in_if.sv =====
// ----------------------------------------------------------------------------
// qrs_in_if
// Coefficient channel: valid/ready with one a, b, c set per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface qrs_in_if import qrs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CoefW-1:0] coef_a;
  logic signed [CoefW-1:0] coef_b;
  logic signed [CoefW-1:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface
`default_nettype wire

// ===== rtl/qrs_out_if.sv =====
// ----------------------------------------------------------------------------
// qrs_out_if
// Result channel: valid/ready with one root pair per beat.
// ----------------------------------------------------------------------------
`default_nettype none
interface qrs_out_if import qrs_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             root_kind;
  logic signed [OutW-1:0] first_value;
  logic signed [OutW-1:0] second_value;
  logic                   saturated;

  modport source (output valid, root_kind, first_value, second_value, saturated,
                  input ready);
  modport sink   (input valid, root_kind, first_value, second_value, saturated,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c from Q8.8 coefficients, as saturated Q16.16.
// ----------------------------------------------------------------------------
// The solver takes one coefficient beat per cycle while the output is not
// stalled and returns one result beat per coefficient set, in order, through
// one product stage, one discriminant stage, 33 square-root stages (one root
// digit each), one numerator setup stage, 35 divider stages (one quotient bit
// each, two dividers side by side) and the output register.
// The whole pipeline advances together; a stall at the output holds every
// stage and deasserts in_bus.ready.
`default_nettype none
module quadratic_root_solver import qrs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qrs_in_if.sink     in_bus,
  qrs_out_if.source  out_bus
);

  logic adv;
  logic out_valid_r;

  assign adv          = !out_valid_r || out_bus.ready;
  assign in_bus.ready = adv;

  // --------------------------------------------------------------------------
  // Products
  logic                      p1_v_r;
  logic signed [CoefW-1:0]   p1_a_r, p1_b_r;
  logic signed [2*CoefW-1:0] p1_bb_r, p1_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_a_r  <= in_bus.coef_a;
      p1_b_r  <= in_bus.coef_b;
      p1_bb_r <= in_bus.coef_b * in_bus.coef_b;
      p1_ac_r <= in_bus.coef_a * in_bus.coef_c;
    end
  end

  // --------------------------------------------------------------------------
  // Discriminant, classification, numerator and denominator
  logic signed [DiscW-1:0] disc;
  logic [DiscW-1:0]        disc_mag;
  qrs_meta_t               meta_nxt;

  always_comb begin
    disc = {{2{p1_bb_r[2*CoefW-1]}}, p1_bb_r} - {p1_ac_r, 2'b00};
    disc_mag = disc[DiscW-1] ? DiscW'(-disc) : DiscW'(disc);
    meta_nxt.nb  = -$signed({p1_b_r[CoefW-1], p1_b_r, {OutFrac{1'b0}}});
    meta_nxt.den = $signed({p1_a_r[CoefW-1], p1_a_r, 1'b0});
    if (p1_a_r == '0) begin
      meta_nxt.kind = KIND_A_ZERO;
    end else if (disc == '0) begin
      meta_nxt.kind = KIND_DOUBLE;
    end else if (disc[DiscW-1]) begin
      meta_nxt.kind = KIND_COMPLEX;
    end else begin
      meta_nxt.kind = KIND_TWO_REAL;
    end
  end

  // --------------------------------------------------------------------------
  // Square root pipeline: stage 0 is the discriminant register
  logic              sq_v_r    [0:SqSteps];
  qrs_meta_t         sq_meta_r [0:SqSteps];
  logic [RadW-1:0]   sq_rad_r  [0:SqSteps];
  logic [RemW-1:0]   sq_rem_r  [0:SqSteps];
  logic [RootW-1:0]  sq_root_r [0:SqSteps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_meta_r[0] <= meta_nxt;
      sq_rad_r[0]  <= {disc_mag, {(2 * OutFrac){1'b0}}};
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < SqSteps; k++) begin : g_sq
    logic [RemW-1:0] rem_sh, trial;
    logic            take;

    // shift in the next digit pair and try the next root bit
    always_comb begin
      rem_sh = {sq_rem_r[k][RemW-3:0], sq_rad_r[k][RadW-1-2*k -: 2]};
      trial  = {1'b0, sq_root_r[k], 2'b01};
      take   = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_r[k+1] <= sq_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_meta_r[k+1] <= sq_meta_r[k];
        sq_rad_r[k+1]  <= sq_rad_r[k];
        sq_rem_r[k+1]  <= take ? rem_sh - trial : rem_sh;
        sq_root_r[k+1] <= {sq_root_r[k][RootW-2:0], take};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Numerator setup: pick operands by root kind, split sign and magnitude
  logic signed [NumSW-1:0] n1, n2, s_ext, nb_ext;
  logic signed [DenW-1:0]  d1, d2;
  qrs_meta_t               sq_last;

  always_comb begin
    sq_last = sq_meta_r[SqSteps];
    s_ext   = $signed({3'b000, sq_root_r[SqSteps]});
    nb_ext  = NumSW'(sq_last.nb);
    d1      = sq_last.den;
    if (sq_last.kind == KIND_COMPLEX) begin
      n1 = nb_ext;
      n2 = s_ext;
      d2 = sq_last.den[DenW-1] ? -sq_last.den : sq_last.den;
    end else begin
      n1 = nb_ext + s_ext;
      n2 = nb_ext - s_ext;
      d2 = sq_last.den;
    end
  end

  logic              dv_v_r    [0:DvSteps];
  root_kind_t        dv_kind_r [0:DvSteps];
  logic              dv_neg1_r [0:DvSteps];
  logic              dv_neg2_r [0:DvSteps];
  logic [NumW-1:0]   dv_n1_r   [0:DvSteps];
  logic [NumW-1:0]   dv_n2_r   [0:DvSteps];
  logic [DmagW-1:0]  dv_d1_r   [0:DvSteps];
  logic [DmagW-1:0]  dv_d2_r   [0:DvSteps];
  logic [DmagW-1:0]  dv_r1_r   [0:DvSteps];
  logic [DmagW-1:0]  dv_r2_r   [0:DvSteps];
  logic [NumW-1:0]   dv_q1_r   [0:DvSteps];
  logic [NumW-1:0]   dv_q2_r   [0:DvSteps];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[SqSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_kind_r[0] <= sq_last.kind;
      dv_neg1_r[0] <= n1[NumSW-1] ^ d1[DenW-1];
      dv_neg2_r[0] <= n2[NumSW-1] ^ d2[DenW-1];
      dv_n1_r[0]   <= n1[NumSW-1] ? NumW'(-n1) : NumW'(n1);
      dv_n2_r[0]   <= n2[NumSW-1] ? NumW'(-n2) : NumW'(n2);
      dv_d1_r[0]   <= d1[DenW-1] ? DmagW'(-d1) : DmagW'(d1);
      dv_d2_r[0]   <= d2[DenW-1] ? DmagW'(-d2) : DmagW'(d2);
      dv_r1_r[0]   <= '0;
      dv_r2_r[0]   <= '0;
      dv_q1_r[0]   <= '0;
      dv_q2_r[0]   <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring dividers, one quotient bit per stage, MSB first
  for (genvar j = 0; j < DvSteps; j++) begin : g_dv
    logic [DmagW:0] sh1, sh2;
    logic           t1, t2;

    always_comb begin
      sh1 = {dv_r1_r[j], dv_n1_r[j][NumW-1-j]};
      sh2 = {dv_r2_r[j], dv_n2_r[j][NumW-1-j]};
      t1  = sh1 >= {1'b0, dv_d1_r[j]};
      t2  = sh2 >= {1'b0, dv_d2_r[j]};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_kind_r[j+1] <= dv_kind_r[j];
        dv_neg1_r[j+1] <= dv_neg1_r[j];
        dv_neg2_r[j+1] <= dv_neg2_r[j];
        dv_n1_r[j+1]   <= dv_n1_r[j];
        dv_n2_r[j+1]   <= dv_n2_r[j];
        dv_d1_r[j+1]   <= dv_d1_r[j];
        dv_d2_r[j+1]   <= dv_d2_r[j];
        dv_r1_r[j+1]   <= t1 ? DmagW'(sh1 - {1'b0, dv_d1_r[j]}) : DmagW'(sh1);
        dv_r2_r[j+1]   <= t2 ? DmagW'(sh2 - {1'b0, dv_d2_r[j]}) : DmagW'(sh2);
        dv_q1_r[j+1]   <= {dv_q1_r[j][NumW-2:0], t1};
        dv_q2_r[j+1]   <= {dv_q2_r[j][NumW-2:0], t2};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Apply sign, clip to Q16.16 and register the result beat
  localparam logic signed [NumSW-1:0] MaxOut = NumSW'((64'sd1 <<< (OutW - 1)) - 1);
  localparam logic signed [NumSW-1:0] MinOut = -NumSW'(64'sd1 <<< (OutW - 1));

  logic signed [NumSW-1:0] v1, v2;
  logic signed [OutW-1:0]  c1, c2;
  logic                    sat1, sat2;
  root_kind_t              kind_last;

  always_comb begin
    kind_last = dv_kind_r[DvSteps];
    v1 = dv_neg1_r[DvSteps] ? -$signed({1'b0, dv_q1_r[DvSteps]})
                            :  $signed({1'b0, dv_q1_r[DvSteps]});
    v2 = dv_neg2_r[DvSteps] ? -$signed({1'b0, dv_q2_r[DvSteps]})
                            :  $signed({1'b0, dv_q2_r[DvSteps]});
    sat1 = (v1 > MaxOut) || (v1 < MinOut);
    sat2 = (v2 > MaxOut) || (v2 < MinOut);
    c1 = (v1 > MaxOut) ? OutW'(MaxOut) : (v1 < MinOut) ? OutW'(MinOut) : OutW'(v1);
    c2 = (v2 > MaxOut) ? OutW'(MaxOut) : (v2 < MinOut) ? OutW'(MinOut) : OutW'(v2);
  end

  logic [1:0]             out_kind_r;
  logic signed [OutW-1:0] out_first_r, out_second_r;
  logic                   out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v_r[DvSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind_r <= kind_last;
      if (kind_last == KIND_A_ZERO) begin
        out_first_r  <= '0;
        out_second_r <= '0;
        out_sat_r    <= 1'b0;
      end else begin
        out_first_r  <= c1;
        out_second_r <= c2;
        out_sat_r    <= sat1 || sat2;
      end
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.root_kind    = out_kind_r;
  assign out_bus.first_value  = out_first_r;
  assign out_bus.second_value = out_second_r;
  assign out_bus.saturated    = out_sat_r;

endmodule
`default_nettype wire

// ===== rtl/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks on the result channel of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_checker import qrs_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [1:0]             root_kind,
  input wire logic signed [OutW-1:0] first_value,
  input wire logic signed [OutW-1:0] second_value,
  input wire logic                   saturated
);

  // hold a stalled result beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(first_value) &&
      $stable(second_value) && $stable(root_kind) && $stable(saturated))
    else $error("stalled result beat changed");

  // zero a: all values cleared
  a_azero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && root_kind == KIND_A_ZERO |->
      first_value == '0 && second_value == '0 && !saturated)
    else $error("zero-a result not cleared");

  // double root: both values equal
  a_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && root_kind == KIND_DOUBLE |-> first_value == second_value)
    else $error("double root values differ");

  // complex pair: imaginary magnitude never negative
  a_imag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && root_kind == KIND_COMPLEX |-> !second_value[OutW-1])
    else $error("negative imaginary magnitude");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .root_kind    (out_bus.root_kind),
  .first_value  (out_bus.first_value),
  .second_value (out_bus.second_value),
  .saturated    (out_bus.saturated)
);
`default_nettype wire
